### rtl/aes_encrypt_rounds_macros.svh
// Assertion helpers for the RTL.
`ifndef AES_ENCRYPT_ROUNDS_MACROS_SVH
`define AES_ENCRYPT_ROUNDS_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define AER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the antecedent implies the consequent in the next cycle.
`define AER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/aes_er_pkg.sv
`timescale 1ns / 1ps
package aes_er_pkg;

  localparam int unsigned BlockBits = 128;
  localparam int unsigned InDataBits = 136;

  typedef logic [BlockBits-1:0] block_t;

  typedef enum logic {
    ACT_KEY_WRITE = 1'b0,
    ACT_ENCRYPT   = 1'b1
  } action_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### rtl/aes_encrypt_rounds.sv
`timescale 1ns / 1ps
// Channel  Direction  tuser       tdata
// in_      slave      action      round_number, word_high, word_low, pad
// out_     master     (none)      cipher_high, cipher_low
//
// An encryption passes through the input register and then one register stage per round;
// one block enters per clock while the output is taken.
// A key write is held off until the input register and every round stage but the last are empty.
// When out_tready is low with a result waiting, every stage holds; nothing is lost.
// Reset (synchronous, rst_n low) clears the valid bits; round keys are undefined until written.
`include "aes_encrypt_rounds_macros.svh"
module aes_encrypt_rounds #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [0:0]    in_tuser,   // action
  input  logic [135:0]  in_tdata,   // round_number, word_high, word_low, zero pad
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata   // cipher_high, cipher_low
);

  logic [ROUND_COUNT:0] vld;
  aes_er_pkg::block_t   st [ROUND_COUNT+1];
  logic [ROUND_COUNT-1:0][127:0] keys;
  logic advance;
  logic busy;
  logic key_wr;
  logic in_valid_r;
  aes_er_pkg::block_t in_state_r;

  assign advance   = !vld[ROUND_COUNT] || out_tready;
  assign busy      = |vld[ROUND_COUNT-1:0];
  assign in_tready = advance &&
                     (in_tuser[0] == aes_er_pkg::ACT_ENCRYPT || !busy);
  assign key_wr    = in_tvalid && in_tready && in_tuser[0] == aes_er_pkg::ACT_KEY_WRITE;

  aes_er_keys #(.RoundCount(ROUND_COUNT)) u_keys (
    .clk      (clk),
    .wr_en    (key_wr),
    .wr_index (in_tdata[3:0]),
    .wr_key   ({in_tdata[67:4], in_tdata[131:68]}),
    .keys     (keys)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r <= in_tvalid && in_tuser[0] == aes_er_pkg::ACT_ENCRYPT;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_state_r <= {in_tdata[67:4], in_tdata[131:68]};
    end
  end

  assign vld[0] = in_valid_r;
  assign st[0]  = in_state_r;

  for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
    aes_er_round #(.Mix(k + 1 < ROUND_COUNT)) u_round (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (advance),
      .in_valid    (vld[k]),
      .in_state    (st[k]),
      .round_key   (keys[k]),
      .out_valid_r (vld[k+1]),
      .out_state_r (st[k+1])
    );
  end

  assign out_tvalid = vld[ROUND_COUNT];
  assign out_tdata  = {st[ROUND_COUNT][63:0], st[ROUND_COUNT][127:64]};

  `AER_ASSERT_IMPL(a_key_wr_idle, clk, rst_n, key_wr, !busy)
  `AER_ASSERT_NEXT(a_stall_hold, clk, rst_n, !advance, $stable(vld))
  `AER_ASSERT_IMPL(a_out_from_pipe, clk, rst_n, $rose(out_tvalid), $past(vld[ROUND_COUNT-1]))

endmodule

### rtl/aes_er_round.sv
`timescale 1ns / 1ps
module aes_er_round #(
  parameter bit Mix = 1'b1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  aes_er_pkg::block_t  in_state,
  input  aes_er_pkg::block_t  round_key,
  output logic                out_valid_r,
  output aes_er_pkg::block_t  out_state_r
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  aes_er_pkg::block_t state_nxt;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = in_state[127-8*i -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[4*c+r] = aes_er_pkg::SBOX[s[4*((c+r)%4)+r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (Mix) begin
        m[4*c]   = t[4*c]   ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                   ^ aes_er_pkg::xtime(t[4*c] ^ t[4*c+1]);
        m[4*c+1] = t[4*c+1] ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                   ^ aes_er_pkg::xtime(t[4*c+1] ^ t[4*c+2]);
        m[4*c+2] = t[4*c+2] ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                   ^ aes_er_pkg::xtime(t[4*c+2] ^ t[4*c+3]);
        m[4*c+3] = t[4*c+3] ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                   ^ aes_er_pkg::xtime(t[4*c+3] ^ t[4*c]);
      end else begin
        m[4*c]   = t[4*c];
        m[4*c+1] = t[4*c+1];
        m[4*c+2] = t[4*c+2];
        m[4*c+3] = t[4*c+3];
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_nxt[127-8*i -: 8] = m[i] ^ round_key[127-8*i -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_state_r <= state_nxt;
    end
  end

endmodule

### rtl/aes_er_keys.sv
`timescale 1ns / 1ps
module aes_er_keys #(
  parameter int unsigned RoundCount = 10
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [3:0]                           wr_index,
  input  aes_er_pkg::block_t                   wr_key,
  output logic [RoundCount-1:0][127:0]         keys
);

  aes_er_pkg::block_t key_r [RoundCount];

  always_ff @(posedge clk) begin
    for (int k = 0; k < RoundCount; k++) begin
      if (wr_en && wr_index == 4'(k)) begin
        key_r[k] <= wr_key;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < RoundCount; k++) begin
      keys[k] = key_r[k];
    end
  end

endmodule

### test/tb_aes_encrypt_rounds.sv
`timescale 1ns / 1ps
module tb_aes_encrypt_rounds;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned WatchdogLimit = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [0:0] in_tuser = '0;
  logic [135:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;

  aes_er_pkg::block_t round_keys [NumRounds];
  aes_er_pkg::block_t cipher_queue [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  aes_encrypt_rounds dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Nine full rounds and a last round without MixColumns, no initial whitening.
  function automatic aes_er_pkg::block_t encrypt_block(input aes_er_pkg::block_t plain);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    aes_er_pkg::block_t key, result;
    for (int i = 0; i < 16; i++) s[i] = plain[127-8*i -: 8];
    for (int k = 0; k < NumRounds; k++) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) t[4*c+r] = aes_er_pkg::SBOX[s[4*((c+r)%4)+r]];
      if (k < NumRounds - 1) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c] = a0 ^ all ^ aes_er_pkg::xtime(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ aes_er_pkg::xtime(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ aes_er_pkg::xtime(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ aes_er_pkg::xtime(a3 ^ a0);
        end
      end
      key = round_keys[k];
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ key[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) result[127-8*i -: 8] = s[i];
    return result;
  endfunction

  task automatic send_item(input aes_er_pkg::action_t act, input logic [3:0] round_num,
                           input logic [63:0] word_high, input logic [63:0] word_low);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {4'b0, word_low, word_high, round_num};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act == aes_er_pkg::ACT_KEY_WRITE) begin
      if (round_num < NumRounds) round_keys[round_num] = {word_high, word_low};
    end else begin
      cipher_queue.push_back(encrypt_block({word_high, word_low}));
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    aes_er_pkg::block_t expected;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_queue.size() == 0) begin
        $display("%0t: unexpected ciphertext %h", $time, out_tdata);
        error_count++;
      end else begin
        expected = cipher_queue.pop_front();
        if (out_tdata[63:0] !== expected[127:64]) begin
          $display("%0t: cipher_high expected %h actual %h", $time,
                   expected[127:64], out_tdata[63:0]);
          error_count++;
        end
        if (out_tdata[127:64] !== expected[63:0]) begin
          $display("%0t: cipher_low expected %h actual %h", $time,
                   expected[63:0], out_tdata[127:64]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_key_writes();
    for (int k = 0; k < NumRounds; k++) begin
      send_item(aes_er_pkg::ACT_KEY_WRITE, k[3:0], {$urandom, $urandom},
                {$urandom, $urandom});
    end
    send_item(aes_er_pkg::ACT_KEY_WRITE, 4'd0, '0, '0);
    send_item(aes_er_pkg::ACT_KEY_WRITE, 4'd9, '1, '1);
    for (int k = NumRounds; k < 16; k++) begin
      send_item(aes_er_pkg::ACT_KEY_WRITE, k[3:0], {$urandom, $urandom},
                {$urandom, $urandom});
    end
  endtask

  task automatic test_directed_blocks();
    send_item(aes_er_pkg::ACT_ENCRYPT, 4'd0, '0, '0);
    send_item(aes_er_pkg::ACT_ENCRYPT, 4'd15, '1, '1);
    send_item(aes_er_pkg::ACT_ENCRYPT, 4'd5, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_item(aes_er_pkg::ACT_KEY_WRITE, 4'd4, 64'h8080808080808080, 64'h0101010101010101);
    send_item(aes_er_pkg::ACT_ENCRYPT, 4'd10, 64'h8080808080808080, 64'h7f7f7f7f7f7f7f7f);
    send_item(aes_er_pkg::ACT_ENCRYPT, 4'd3, 64'hffffffff00000000, 64'h00000000ffffffff);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall, input int count);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        send_item(aes_er_pkg::ACT_KEY_WRITE, 4'($urandom_range(15)), rand_word(),
                  rand_word());
      end else begin
        send_item(aes_er_pkg::ACT_ENCRYPT, 4'($urandom_range(15)), rand_word(),
                  rand_word());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_key_writes();
    test_directed_blocks();
    test_random_phase(0, 0, 360);
    test_random_phase(65, 0, 360);
    test_random_phase(0, 65, 360);
    test_random_phase(11, 11, 360);
    @(negedge clk);
    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/aes_er_pkg.sv
rtl/aes_er_round.sv
rtl/aes_er_keys.sv
rtl/aes_encrypt_rounds.sv
test/tb_aes_encrypt_rounds.sv
